FILE: rtl/core/chs_pkg.sv
// Shared types, codes and defaults for the chained hash set.
`default_nettype none

package chs_pkg;

  localparam int KEY_W            = 63;
  localparam int BUCKET_COUNT_DEF = 4093;
  localparam int NODE_POOL_DEF    = 4096;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  typedef struct packed {
    logic             opcode;
    logic [KEY_W-1:0] key;
  } in_t;

  typedef struct packed {
    logic found;
    logic added;
    logic pool_full;
  } out_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MOD,
    ST_HEAD,
    ST_LINK,
    ST_CMP
  } st_t;

endpackage

`default_nettype wire

FILE: rtl/core/chained_hash_set_unit.sv
// Top level of the chained hash set: modulo unit, chain walker and table memories.
`default_nettype none

// Set of 63-bit keys held as a separately chained hash table in on-chip memory.
//
// Command channel: drive cmd (opcode, key) and raise start; the beat is taken
// at a rising edge where start is high and busy is low. busy stays high until
// the command finishes.
// Result channel: done is high for exactly one cycle with result (found,
// added, pool_full) valid in that cycle. The receiver cannot stall it, so
// every result must be captured in its strobe cycle.
//
// Steps per command: the bucket index (key mod BUCKET_COUNT, one 8-bit key
// digit per cycle through a shared fold step: constant table, add, two
// compare-subtracts), the bucket head read, then per chain node visited a node
// memory read and a key compare, and on a miss a final link check that sees the
// end of the chain. done is high in the first cycle with busy low, and a new
// start can be taken then.
//
// Reset: rst clears the node count and starts a pass over the bucket head
// memory that writes one head to empty per cycle; busy is high throughout
// that pass. Node memories are never cleared.
// An insert that finds the pool exhausted is dropped and flagged pool_full.
module chained_hash_set_unit import chs_pkg::*; #(
  parameter int BUCKET_COUNT = BUCKET_COUNT_DEF,
  parameter int NODE_POOL    = NODE_POOL_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  wire in_t  cmd,
  output logic      busy,
  output logic      done,
  output out_t      result
);

  localparam int BKT_W = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1;
  localparam int NODE_W = (NODE_POOL > 1) ? $clog2(NODE_POOL) : 1;
  localparam int PTR_W = $clog2(NODE_POOL + 1);
  localparam int DIG_W = 8;
  localparam int NUM_DIG = (KEY_W + DIG_W - 1) / DIG_W;
  localparam int PAD_W = NUM_DIG * DIG_W;
  localparam int IDX_W = $clog2(NUM_DIG);

  // Sequencer state
  st_t state, state_next;

  // Command and bucket computation
  logic [KEY_W-1:0] key_q;
  logic             op_q;
  logic [IDX_W-1:0] dig_idx;
  logic [BKT_W-1:0] rem;
  logic [BKT_W-1:0] clr_addr;

  // Chain walk
  logic [PTR_W-1:0] head_q;
  logic             first;
  logic [PTR_W-1:0] nodes_used;
  logic [KEY_W-1:0] node_key_q;
  logic [PTR_W-1:0] node_next_q;

  // Tables
  logic [PTR_W-1:0] heads         [BUCKET_COUNT];
  logic [KEY_W-1:0] node_key_mem  [NODE_POOL];
  logic [PTR_W-1:0] node_next_mem [NODE_POOL];

  // Combinational control
  logic [PAD_W-1:0]       key_pad;
  logic [DIG_W-1:0]       digit;
  logic [BKT_W+DIG_W-1:0] fold_in;
  logic [BKT_W-1:0]       fold_tbl [2**DIG_W];
  logic [BKT_W:0]         fold_sum;
  logic [BKT_W:0]         fold_red;
  logic [BKT_W:0]         fold_fin;
  logic [BKT_W-1:0]       rem_step;
  logic [PTR_W-1:0] link;
  logic [PTR_W-1:0] link_node;
  logic             link_ok;
  logic             hit;
  logic             finish;
  logic             present;
  logic             node_rd;
  logic             pool_empty;
  logic             ins_new;
  logic             ins_drop;

  // Fold table: entry h holds (h * 2**BKT_W) mod BUCKET_COUNT.
  for (genvar g = 0; g < 2**DIG_W; g++) begin : g_fold
    assign fold_tbl[g] = BKT_W'((64'(g) << BKT_W) % 64'(BUCKET_COUNT));
  end

  // Shared modulo step: shift the next key digit into the partial remainder,
  // fold the bits above BKT_W through the table, then subtract the bucket
  // count up to twice to bring the sum back below it.
  assign key_pad  = PAD_W'(key_q);
  assign digit    = key_pad[dig_idx*DIG_W +: DIG_W];
  assign fold_in  = {rem, digit};
  assign fold_sum = {1'b0, fold_tbl[fold_in[BKT_W+DIG_W-1:BKT_W]]} +
                    {1'b0, fold_in[BKT_W-1:0]};
  assign fold_red = (fold_sum >= (BKT_W+1)'(BUCKET_COUNT))
                  ? fold_sum - (BKT_W+1)'(BUCKET_COUNT) : fold_sum;
  assign fold_fin = (fold_red >= (BKT_W+1)'(BUCKET_COUNT))
                  ? fold_red - (BKT_W+1)'(BUCKET_COUNT) : fold_red;
  assign rem_step = fold_fin[BKT_W-1:0];

  // Link under test: bucket head first, then the next pointer of each node.
  // A link of zero ends the chain; a link past the allocated nodes ends it too.
  assign link      = first ? head_q : node_next_q;
  assign link_node = link - PTR_W'(1);
  assign link_ok   = (link != '0) && (link_node < nodes_used);
  assign hit       = (node_key_q == key_q);

  assign pool_empty = (nodes_used == PTR_W'(NODE_POOL));
  assign ins_new    = finish && (op_q == OP_INSERT) && !present && !pool_empty;
  assign ins_drop   = finish && (op_q == OP_INSERT) && !present && pool_empty;

  assign busy = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    finish     = 1'b0;
    present    = 1'b0;
    node_rd    = 1'b0;
    case (state)
      ST_CLEAR: begin
        if (clr_addr == BKT_W'(BUCKET_COUNT - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) state_next = ST_MOD;
      end
      ST_MOD: begin
        if (dig_idx == '0) state_next = ST_HEAD;
      end
      ST_HEAD: begin
        state_next = ST_LINK;
      end
      ST_LINK: begin
        if (link_ok) begin
          node_rd    = 1'b1;
          state_next = ST_CMP;
        end else begin
          finish     = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_CMP: begin
        if (hit) begin
          finish     = 1'b1;
          present    = 1'b1;
          state_next = ST_IDLE;
        end else begin
          state_next = ST_LINK;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr   <= '0;
      nodes_used <= '0;
      done       <= 1'b0;
    end else begin
      // Advance the clearing pass one head per cycle
      if (state == ST_CLEAR) clr_addr <= clr_addr + BKT_W'(1);
      done <= finish;
      if (ins_new) nodes_used <= nodes_used + PTR_W'(1);
    end
  end

  // Command capture, modulo iteration and result beat
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && start) begin
      key_q   <= cmd.key;
      op_q    <= cmd.opcode;
      dig_idx <= IDX_W'(NUM_DIG - 1);
      rem     <= '0;
      first   <= 1'b1;
    end
    if (state == ST_MOD) begin
      rem     <= rem_step;
      dig_idx <= dig_idx - IDX_W'(1);
    end
    // After the first compare, follow node next pointers
    if (state == ST_CMP && !hit) first <= 1'b0;
    if (finish) begin
      result.found     <= present;
      result.added     <= ins_new;
      result.pool_full <= ins_drop;
    end
  end

  // Bucket head memory: clearing pass or head update on insert, one read port
  always_ff @(posedge clk) begin
    if (state == ST_CLEAR) begin
      heads[clr_addr] <= '0;
    end else if (ins_new) begin
      heads[rem] <= nodes_used + PTR_W'(1);
    end
    if (state == ST_HEAD) head_q <= heads[rem];
  end

  // Node memories: new node links to the old head, read one node per visit
  always_ff @(posedge clk) begin
    if (ins_new) begin
      node_key_mem[nodes_used[NODE_W-1:0]]  <= key_q;
      node_next_mem[nodes_used[NODE_W-1:0]] <= head_q;
    end
    if (node_rd) begin
      node_key_q  <= node_key_mem[link_node[NODE_W-1:0]];
      node_next_q <= node_next_mem[link_node[NODE_W-1:0]];
    end
  end

  // Checks
  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    done |-> $onehot0({result.found, result.added, result.pool_full}))
    else $error("result flags not exclusive");

  a_pool_bound: assert property (@(posedge clk) disable iff (rst)
    nodes_used <= PTR_W'(NODE_POOL))
    else $error("node count past pool size");

  a_added_counts: assert property (@(posedge clk) disable iff (rst)
    (done && result.added) |-> (nodes_used == $past(nodes_used) + PTR_W'(1)))
    else $error("added result without node allocation");

  a_full_only_when_full: assert property (@(posedge clk) disable iff (rst)
    (done && result.pool_full) |-> (nodes_used == PTR_W'(NODE_POOL)))
    else $error("pool_full while nodes remain");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("back-to-back done strobes");

endmodule

`default_nettype wire
